// ----- hw/rtl/rvalu_pkg.sv -----
// shared types, op codes and helpers of the rv64 register alu
package rvalu_pkg;

    localparam int XLEN = 64;
    localparam int HALF = 32;
    localparam int OP_W = 4;
    localparam int S_DATA_W = 136;

    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_SLL  = 4'd2;
    localparam logic [OP_W-1:0] OP_SLT  = 4'd3;
    localparam logic [OP_W-1:0] OP_SLTU = 4'd4;
    localparam logic [OP_W-1:0] OP_XOR  = 4'd5;
    localparam logic [OP_W-1:0] OP_SRL  = 4'd6;
    localparam logic [OP_W-1:0] OP_SRA  = 4'd7;
    localparam logic [OP_W-1:0] OP_OR   = 4'd8;
    localparam logic [OP_W-1:0] OP_AND  = 4'd9;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd10;
    localparam logic [OP_W-1:0] OP_ADDW = 4'd11;
    localparam logic [OP_W-1:0] OP_SUBW = 4'd12;
    localparam logic [OP_W-1:0] OP_SLLW = 4'd13;
    localparam logic [OP_W-1:0] OP_SRLW = 4'd14;
    localparam logic [OP_W-1:0] OP_SRAW = 4'd15;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [XLEN-1:0] src_a;
        logic [XLEN-1:0] src_b;
    } rvalu_item_t;

    typedef struct packed {
        logic            is_mul;
        logic [XLEN-1:0] alu_res;
        logic [XLEN-1:0] pp_ll;
        logic [HALF-1:0] pp_lh;
        logic [HALF-1:0] pp_hl;
    } rvalu_exec_t;

    function automatic logic [XLEN-1:0] sext32(input logic [HALF-1:0] v);
        sext32 = {{HALF{v[HALF-1]}}, v};
    endfunction

endpackage

// ----- hw/rtl/rv64_register_alu.sv -----
// top level of the rv64 register alu: input register, execute stage, merge stage
// an accepted input beat passes the input register, the execute register and the merge register to its result beat
// throughput: one beat per cycle while m_tready holds; three registered stages, each with its own valid bit
// the multiply is split into 32x32 partial products summed in the last stage
// a stalled stage holds its beat while bubbles upstream of it still fill
// reset: synchronous active-low aresetn clears all valid bits; data registers are not reset
module rv64_register_alu
    import rvalu_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op[3:0], src_a[67:4], src_b[131:68], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [XLEN-1:0]     m_tdata    // result[63:0]
);

    logic        in_valid_reg;
    rvalu_item_t in_item_reg;
    logic        exec_ready;
    logic        exec_valid;
    rvalu_exec_t exec_data;
    logic        merge_ready;

    assign s_tready = !in_valid_reg || exec_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.op    <= s_tdata[OP_W-1:0];
            in_item_reg.src_a <= s_tdata[OP_W+XLEN-1:OP_W];
            in_item_reg.src_b <= s_tdata[OP_W+2*XLEN-1:OP_W+XLEN];
        end
    end

    rvalu_exec u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (exec_ready),
        .in_item   (in_item_reg),
        .out_valid (exec_valid),
        .out_ready (merge_ready),
        .out_data  (exec_data)
    );

    rvalu_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (exec_valid),
        .in_ready   (merge_ready),
        .in_data    (exec_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

endmodule

// ----- hw/rtl/rvalu_exec.sv -----
// execute stage: logic, add, compare and shift results plus multiplier partial products
module rvalu_exec
    import rvalu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  rvalu_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output rvalu_exec_t out_data
);

    logic            valid_reg;
    rvalu_exec_t     data_reg;
    rvalu_exec_t     data_next;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
    logic [XLEN-1:0] sum;
    logic [XLEN-1:0] diff;
    logic [5:0]      sh64;
    logic [4:0]      sh32;
    logic [HALF-1:0] sllw_w;
    logic [HALF-1:0] srlw_w;
    logic [HALF-1:0] sraw_w;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign a      = in_item.src_a;
    assign b      = in_item.src_b;
    assign sum    = a + b;
    assign diff   = a - b;
    assign sh64   = b[5:0];
    assign sh32   = b[4:0];
    assign sllw_w = a[HALF-1:0] << sh32;
    assign srlw_w = a[HALF-1:0] >> sh32;
    assign sraw_w = $signed(a[HALF-1:0]) >>> sh32;

    always_comb begin
        data_next.is_mul = (in_item.op == OP_MUL);
        data_next.pp_ll  = {{HALF{1'b0}}, a[HALF-1:0]} * {{HALF{1'b0}}, b[HALF-1:0]};
        data_next.pp_lh  = a[HALF-1:0] * b[XLEN-1:HALF];
        data_next.pp_hl  = a[XLEN-1:HALF] * b[HALF-1:0];
        case (in_item.op)
            OP_ADD:  data_next.alu_res = sum;
            OP_SUB:  data_next.alu_res = diff;
            OP_SLL:  data_next.alu_res = a << sh64;
            OP_SLT:  data_next.alu_res = {63'd0, $signed(a) < $signed(b)};
            OP_SLTU: data_next.alu_res = {63'd0, a < b};
            OP_XOR:  data_next.alu_res = a ^ b;
            OP_SRL:  data_next.alu_res = a >> sh64;
            OP_SRA:  data_next.alu_res = $signed(a) >>> sh64;
            OP_OR:   data_next.alu_res = a | b;
            OP_AND:  data_next.alu_res = a & b;
            OP_ADDW: data_next.alu_res = sext32(sum[HALF-1:0]);
            OP_SUBW: data_next.alu_res = sext32(diff[HALF-1:0]);
            OP_SLLW: data_next.alu_res = sext32(sllw_w);
            OP_SRLW: data_next.alu_res = sext32(srlw_w);
            OP_SRAW: data_next.alu_res = sext32(sraw_w);
            default: data_next.alu_res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ----- hw/rtl/rvalu_merge.sv -----
// merge stage: sums the partial products and selects the result into the output register
module rvalu_merge
    import rvalu_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rvalu_exec_t     in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [XLEN-1:0] out_result
);

    logic            valid_reg;
    logic [XLEN-1:0] result_reg;
    logic [XLEN-1:0] result_next;
    logic [HALF-1:0] cross_sum;
    logic [XLEN-1:0] product;

    assign in_ready   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    assign cross_sum   = in_data.pp_lh + in_data.pp_hl;
    assign product     = in_data.pp_ll + {cross_sum, {HALF{1'b0}}};
    assign result_next = in_data.is_mul ? product : in_data.alu_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

endmodule
